[sv/asrs_pkg.sv]
package asrs_pkg;

    localparam int NUM_CHANNELS_DEF = 13;
    localparam int CODE_BITS_DEF    = 10;

    // Configuration registers, one 32-bit word each.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int MASK_W = 13;
    localparam int VREF_W = 16;

    localparam logic [1:0] REG_CHANNEL_MASK   = 2'd0;
    localparam logic [1:0] REG_VREF_MV        = 2'd1;
    localparam logic [1:0] REG_NOTIFY_CHANNEL = 2'd2;
    localparam logic [1:0] REG_NOTIFY_ENABLE  = 2'd3;

    localparam logic [1:0] CMD_STORE   = 2'd0;
    localparam logic [1:0] CMD_RD_CODE = 2'd1;
    localparam logic [1:0] CMD_RD_MV   = 2'd2;

    localparam int unsigned VREF_RESET = 1200;
    localparam int unsigned MV_SCALE   = 1000;

    // vref * 1000 fits in 26 bits, and so does quantum * code for any code width.
    localparam int PROD_W    = 26;
    // Division by 1000 through floor(2^36 / 1000) and one correction step.
    localparam int RECIP_W   = 27;
    localparam int DIV_SHIFT = 36;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 27'd68719476;
    localparam int EST_W     = 17;
    localparam int REM_W     = 11;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  slot_index;
        logic [15:0] slot_word;
        logic [3:0]  channel;
    } req_t;

    typedef struct packed {
        logic [3:0]  stored_channel;
        logic        notify;
        logic [15:0] read_data;
        logic        error;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_MUL,
        ST_EST,
        ST_FIX,
        ST_DONE
    } state_t;

endpackage

[sv/adc_scan_result_store.sv]
// Channel    Signals                                  Word
// ---------  ---------------------------------------  ---------------------------------
// request    req_valid / req_ready / req              cmd, slot_index, slot_word, channel
// response   rsp_valid / rsp_ready / rsp              stored_channel, notify, read_data, error
// config     psel / penable / pwrite / paddr / ...    one 32-bit register per word address
//
// One word is worked on at a time. A store or an error passes through decode and done,
// a code read adds the registered code-memory read, and a millivolt read adds that read
// and then the multiply, reciprocal estimate and correction steps.
// A new word is taken in the cycle its predecessor moves into the response register.
// Reset is asynchronous; the code table reads as zero until a channel is stored, kept
// by one valid flop per entry, so no clearing pass is needed.
// A stalled response holds the block in its final state until the register frees up.
module adc_scan_result_store #(
    parameter int NUM_CHANNELS = asrs_pkg::NUM_CHANNELS_DEF,
    parameter int CODE_BITS    = asrs_pkg::CODE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  asrs_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output asrs_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [asrs_pkg::ADDR_W-1:0]   paddr,
    input  logic [asrs_pkg::DATA_W-1:0]   pwdata,
    output logic [asrs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    import asrs_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int QW = PROD_W - CODE_BITS;
    localparam logic [QW-1:0] QUANTUM_RST = QW'((VREF_RESET * MV_SCALE) >> CODE_BITS);

    // Configuration registers.
    logic [MASK_W-1:0] mask_reg;
    logic [VREF_W-1:0] vref_reg;
    logic [QW-1:0]     quantum_reg;
    logic [3:0]        notify_ch_reg;
    logic              notify_en_reg;
    logic              cfg_we;
    logic [1:0]        cfg_idx;
    logic [PROD_W-1:0] vref_scaled;

    // Sequencer and datapath.
    state_t            state_reg;
    state_t            state_next;
    req_t              req_reg;
    rsp_t              pend_reg;
    rsp_t              pend_next;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic [CODE_BITS-1:0] code_mem [NUM_CHANNELS];
    logic [CODE_BITS-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [EST_W-1:0]  est_reg;
    logic [REM_W-1:0]  rem_reg;

    logic              out_free;
    logic              take_item;
    logic              mem_we;
    logic              rd_en;
    logic              load_pend;
    logic              load_out;

    logic [15:0]       mask_ext;
    logic [NUM_CHANNELS-1:0] slot_hit;
    logic              slot_found;
    logic [3:0]        slot_ch;
    logic              chan_ok;
    logic              is_read;
    logic              read_ok;
    logic [CODE_BITS-1:0] code_rd;
    logic [PROD_W+RECIP_W-1:0] est_full;
    logic [PROD_W:0]   rem_full;
    logic [EST_W-1:0]  mv_full;
    logic [15:0]       mv_sat;

    // ---------------- configuration port ----------------
    assign pready      = 1'b1;
    assign cfg_we      = psel && penable && pwrite;
    assign cfg_idx     = paddr[3:2];
    assign vref_scaled = PROD_W'(pwdata[VREF_W-1:0]) * PROD_W'(MV_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            vref_reg      <= VREF_W'(VREF_RESET);
            quantum_reg   <= QUANTUM_RST;
            notify_ch_reg <= '0;
            notify_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_CHANNEL_MASK:   mask_reg <= pwdata[MASK_W-1:0];
                REG_VREF_MV:
                begin
                    vref_reg    <= pwdata[VREF_W-1:0];
                    quantum_reg <= vref_scaled[PROD_W-1:CODE_BITS];
                end
                REG_NOTIFY_CHANNEL: notify_ch_reg <= pwdata[3:0];
                REG_NOTIFY_ENABLE:  notify_en_reg <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_CHANNEL_MASK:   prdata = DATA_W'(mask_reg);
            REG_VREF_MV:        prdata = DATA_W'(vref_reg);
            REG_NOTIFY_CHANNEL: prdata = DATA_W'(notify_ch_reg);
            REG_NOTIFY_ENABLE:  prdata = DATA_W'(notify_en_reg);
            default:            prdata = '0;
        endcase
    end

    // ---------------- decode of the held word ----------------
    // Slot n belongs to the enabled channel that has exactly n enabled channels below it.
    always_comb
    begin
        mask_ext   = 16'(mask_reg);
        slot_found = 1'b0;
        slot_ch    = '0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            slot_hit[ch] = mask_ext[ch] &&
                ($countones(mask_ext & ((16'd1 << ch) - 16'd1)) == int'(req_reg.slot_index));
        end
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            if (slot_hit[ch])
            begin
                slot_found = 1'b1;
                slot_ch    = slot_ch | 4'(ch);
            end
        end
    end

    assign chan_ok  = {1'b0, req_reg.channel} < 5'(NUM_CHANNELS);
    assign is_read  = (req_reg.cmd == CMD_RD_CODE) || (req_reg.cmd == CMD_RD_MV);
    assign read_ok  = is_read && chan_ok;
    assign out_free = !rsp_valid_reg || rsp_ready;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (req_valid) state_next = ST_DECODE;
            ST_DECODE: state_next = read_ok ? ST_READ : ST_DONE;
            ST_READ:   state_next = (req_reg.cmd == CMD_RD_MV) ? ST_MUL : ST_DONE;
            ST_MUL:    state_next = ST_EST;
            ST_EST:    state_next = ST_FIX;
            ST_FIX:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = req_valid ? ST_DECODE : ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        load_pend = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:   req_ready = 1'b1;
            ST_DECODE:
            begin
                mem_we    = (req_reg.cmd == CMD_STORE) && slot_found;
                rd_en     = read_ok;
                load_pend = !read_ok;
            end
            ST_READ:   load_pend = (req_reg.cmd == CMD_RD_CODE);
            ST_FIX:    load_pend = 1'b1;
            ST_DONE:
            begin
                req_ready = out_free;
                load_out  = out_free;
            end
            default:   ;
        endcase
    end

    assign take_item = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (mem_we)
            begin
                valid_reg[slot_ch[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // ---------------- code memory ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            code_mem[slot_ch[AW-1:0]] <= req_reg.slot_word[CODE_BITS-1:0];
        end
        if (rd_en)
        begin
            rd_data_reg  <= code_mem[req_reg.channel[AW-1:0]];
            rd_valid_reg <= valid_reg[req_reg.channel[AW-1:0]];
        end
    end

    // ---------------- millivolt arithmetic ----------------
    assign code_rd  = rd_valid_reg ? rd_data_reg : '0;
    assign est_full = (PROD_W+RECIP_W)'(prod_reg) * (PROD_W+RECIP_W)'(DIV_RECIP);
    assign rem_full = (PROD_W+1)'(prod_reg) - (PROD_W+1)'(est_reg) * (PROD_W+1)'(MV_SCALE);
    // The estimate is at most one below the true quotient.
    assign mv_full  = est_reg + EST_W'(rem_reg >= REM_W'(MV_SCALE));
    assign mv_sat   = (mv_full > EST_W'(16'hFFFF)) ? 16'hFFFF : mv_full[15:0];

    always_comb
    begin
        pend_next = '0;
        case (state_reg)
            ST_DECODE:
            begin
                if (req_reg.cmd == CMD_STORE)
                begin
                    if (slot_found)
                    begin
                        pend_next.stored_channel = slot_ch;
                        pend_next.notify = notify_en_reg && (notify_ch_reg == slot_ch);
                    end
                    else
                    begin
                        pend_next.error = 1'b1;
                    end
                end
                else
                begin
                    pend_next.error = 1'b1;
                end
            end
            ST_READ:   pend_next.read_data = 16'(code_rd);
            ST_FIX:    pend_next.read_data = mv_sat;
            default:   ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            req_reg <= req;
        end
        if (load_pend)
        begin
            pend_reg <= pend_next;
        end
        if (load_out)
        begin
            rsp_reg <= pend_reg;
        end
        if (state_reg == ST_READ)
        begin
            prod_reg <= PROD_W'(quantum_reg) * PROD_W'(code_rd);
        end
        if (state_reg == ST_MUL)
        begin
            est_reg <= est_full[DIV_SHIFT +: EST_W];
        end
        if (state_reg == ST_EST)
        begin
            rem_reg <= rem_full[REM_W-1:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[sv/asrs_checker.sv]
module asrs_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_ready,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  asrs_pkg::rsp_t  rsp
);

    import asrs_pkg::*;

    // After a word is accepted, req_ready drops while the word is worked on.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request ready right after an accepted word");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response word changed or dropped");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.error |->
            rsp.read_data == 16'd0 && rsp.stored_channel == 4'd0 && !rsp.notify)
        else $error("error response carries data");

    a_notify_store_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.notify |-> rsp.read_data == 16'd0)
        else $error("notify raised on a read response");

endmodule

bind adc_scan_result_store asrs_checker u_asrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
